### src/daisy_chain_interrupt_controller_unit_macros.svh
// Assertion macros for the interrupt controller.
// Included by modules that carry concurrent assertions.
`ifndef DAISY_CHAIN_INTERRUPT_CONTROLLER_UNIT_MACROS_SVH
`define DAISY_CHAIN_INTERRUPT_CONTROLLER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define DCIC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define DCIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### src/dcic_pkg.sv
// Shared types and constants for the interrupt controller.
// No dependencies.
`timescale 1ns / 1ps
package dcic_pkg;
  localparam int unsigned SLOTS = 14;
  localparam int unsigned SLOT_W = 4;

  localparam logic [3:0] OP_READ = 4'd0;
  localparam logic [3:0] OP_WRITE = 4'd1;
  localparam logic [3:0] OP_ULA = 4'd2;
  localparam logic [3:0] OP_LINE = 4'd3;
  localparam logic [3:0] OP_CTC = 4'd4;
  localparam logic [3:0] OP_UART = 4'd5;
  localparam logic [3:0] OP_ACK = 4'd6;
  localparam logic [3:0] OP_RETI = 4'd7;
  localparam logic [3:0] OP_SETIS = 4'd8;

  localparam logic [7:0] REG_NMI = 8'h02;
  localparam logic [7:0] REG_PEND0 = 8'h20;
  localparam logic [7:0] REG_LINEH = 8'h22;
  localparam logic [7:0] REG_LINEL = 8'h23;
  localparam logic [7:0] REG_MODE = 8'hC0;
  localparam logic [7:0] REG_NRL = 8'hC2;
  localparam logic [7:0] REG_NRH = 8'hC3;
  localparam logic [7:0] REG_EN0 = 8'hC4;
  localparam logic [7:0] REG_EN1 = 8'hC5;
  localparam logic [7:0] REG_EN2 = 8'hC6;
  localparam logic [7:0] REG_ST0 = 8'hC8;
  localparam logic [7:0] REG_ST1 = 8'hC9;
  localparam logic [7:0] REG_ST2 = 8'hCA;
  localparam logic [7:0] REG_DMA0 = 8'hCC;
  localparam logic [7:0] REG_DMA1 = 8'hCD;
  localparam logic [7:0] REG_DMA2 = 8'hCE;

  // per-slot view handed down the chain
  typedef struct packed {
    logic req;
    logic ins;
  } slot_t;

  // chain token passed cell to cell
  typedef struct packed {
    logic done;
    logic found;
    logic [SLOT_W-1:0] slot;
    logic first_is_found;
    logic [SLOT_W-1:0] first_is;
  } chain_t;

  function automatic logic [5:0] pack6(input logic [7:0] b);
    return {b[6:4], b[2:0]};
  endfunction

  function automatic logic [7:0] unpack6(input logic [5:0] v);
    return {1'b0, v[5:3], 1'b0, v[2:0]};
  endfunction
endpackage

### src/dcic_cell.sv
// One priority cell of the daisy chain: passes the token to the next slot.
// Depends on dcic_pkg.
`timescale 1ns / 1ps
module dcic_cell #(
  parameter int unsigned INDEX = 0
) (
  input  dcic_pkg::slot_t  slot,
  input  dcic_pkg::chain_t chain_in,
  output dcic_pkg::chain_t chain_out
);
  localparam logic [dcic_pkg::SLOT_W-1:0] IDX = dcic_pkg::SLOT_W'(INDEX);

  always_comb begin
    chain_out = chain_in;
    // winner scan: in-service blocks, else a request wins
    if (!chain_in.done) begin
      if (slot.ins) begin
        chain_out.done = 1'b1;
      end else if (slot.req) begin
        chain_out.done = 1'b1;
        chain_out.found = 1'b1;
        chain_out.slot = IDX;
      end
    end
    // first in-service slot, for return-from-interrupt
    if (!chain_in.first_is_found && slot.ins) begin
      chain_out.first_is_found = 1'b1;
      chain_out.first_is = IDX;
    end
  end
endmodule

### src/dcic_chain.sv
// Row of 14 priority cells giving the winner and the first in-service slot.
// Depends on dcic_pkg and dcic_cell.
`timescale 1ns / 1ps
module dcic_chain (
  input  logic [dcic_pkg::SLOTS-1:0] req,
  input  logic [dcic_pkg::SLOTS-1:0] ins,
  output dcic_pkg::chain_t           result
);
  dcic_pkg::chain_t link [dcic_pkg::SLOTS+1];

  assign link[0] = '0;

  for (genvar i = 0; i < dcic_pkg::SLOTS; i++) begin : g_cell
    dcic_pkg::slot_t s;
    assign s.req = req[i];
    assign s.ins = ins[i];
    dcic_cell #(.INDEX(i)) u_cell (
      .slot(s), .chain_in(link[i]), .chain_out(link[i+1])
    );
  end

  assign result = link[dcic_pkg::SLOTS];
endmodule

### src/daisy_chain_interrupt_controller_unit.sv
// Top level of the interrupt controller: state, register file, output register.
// Depends on dcic_pkg, dcic_chain and the assertion macro header.
// The result of an accepted transaction is registered and valid in the cycle after acceptance.
// Throughput: one transaction per cycle while the output is not stalled; two 14-cell
// priority chains evaluate the state before and after the update in combinational logic.
// Reset: synchronous active-high rst clears all state and the output valid.
`timescale 1ns / 1ps
`include "daisy_chain_interrupt_controller_unit_macros.svh"
module daisy_chain_interrupt_controller_unit #(
  parameter int unsigned CTC_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[3:0], reg_number[11:4], write_data[19:12], source_index[23:20],
  // source_level[24], cpu_im_mode[26:25], zero[31:27]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], read_hit[8], write_taken[9], irq_request[10],
  // vector_out[18:11], dma_request[19], mf_nmi_strobe[20],
  // divmmc_nmi_strobe[21], ctc_enable_strobe[22], zero[23]
  output logic [23:0] m_axis_tdata
);
  localparam logic [7:0] CTC_MASK = 8'((9'd1 << CTC_CHANNELS) - 9'd1);

  logic [3:0] opcode;
  logic [7:0] reg_number, wd;
  logic [3:0] idx;
  logic       lvl;
  logic [1:0] im;
  assign opcode = s_axis_tdata[3:0];
  assign reg_number = s_axis_tdata[11:4];
  assign wd = s_axis_tdata[19:12];
  assign idx = s_axis_tdata[23:20];
  assign lvl = s_axis_tdata[24];
  assign im = s_axis_tdata[26:25];

  // state registers
  logic line_enable, ula_disable, expansion_bus_enable, int_signal_flag;
  logic [8:0] line_target;
  logic [2:0] vector_top;
  logic stackless_nmi, hardware_mode;
  logic [15:0] nmi_return;
  logic [5:0] uart_enables, uart_pending;
  logic [7:0] ctc_enables, ctc_pending;
  logic [1:0] line_ula_pending;
  logic [16:0] dma_enables;
  logic [13:0] in_service;
  logic [5:0] reset_nmi_flags;

  logic line_enable_next, ula_disable_next, expansion_bus_enable_next, int_signal_flag_next;
  logic [8:0] line_target_next;
  logic [2:0] vector_top_next;
  logic stackless_nmi_next, hardware_mode_next;
  logic [15:0] nmi_return_next;
  logic [5:0] uart_enables_next, uart_pending_next;
  logic [7:0] ctc_enables_next, ctc_pending_next;
  logic [1:0] line_ula_pending_next;
  logic [16:0] dma_enables_next;
  logic [13:0] in_service_next;
  logic [5:0] reset_nmi_flags_next;

  logic accept, out_load;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  // request vectors before and after the update
  function automatic logic [13:0] req_vec(
    input logic [1:0] lup, input logic le, input logic ud,
    input logic [5:0] up, input logic [5:0] ue,
    input logic [7:0] cp, input logic [7:0] ce);
    logic [13:0] r;
    r[0] = lup[1] & le;
    r[1] = (|up[1:0]) & (|ue[1:0]);
    r[2] = (|up[4:3]) & (|ue[4:3]);
    r[10:3] = cp & ce;
    r[11] = lup[0] & ~ud;
    r[12] = up[2] & ue[2];
    r[13] = up[5] & ue[5];
    return r;
  endfunction

  dcic_pkg::chain_t pre, post;
  dcic_chain u_pre (
    .req(req_vec(line_ula_pending, line_enable, ula_disable, uart_pending, uart_enables,
                 ctc_pending, ctc_enables)),
    .ins(in_service), .result(pre)
  );
  dcic_chain u_post (
    .req(req_vec(line_ula_pending_next, line_enable_next, ula_disable_next,
                 uart_pending_next, uart_enables_next, ctc_pending_next, ctc_enables_next)),
    .ins(in_service_next), .result(post)
  );

  // read mux
  logic [7:0] rd;
  logic       hit;
  always_comb begin
    rd = 8'hFF;
    hit = 1'b1;
    case (reg_number)
      dcic_pkg::REG_NMI: rd = {reset_nmi_flags[5], 2'b00, reset_nmi_flags[4:0]};
      dcic_pkg::REG_PEND0: rd = {line_ula_pending, 2'b00, ctc_pending[3:0]};
      dcic_pkg::REG_LINEH:
        rd = {int_signal_flag, 4'b0000, ula_disable, line_enable, line_target[8]};
      dcic_pkg::REG_LINEL: rd = line_target[7:0];
      dcic_pkg::REG_MODE: rd = {vector_top, 1'b0, stackless_nmi, im, hardware_mode};
      dcic_pkg::REG_NRL: rd = nmi_return[7:0];
      dcic_pkg::REG_NRH: rd = nmi_return[15:8];
      dcic_pkg::REG_EN0: rd = {expansion_bus_enable, 5'b0, line_enable, ~ula_disable};
      dcic_pkg::REG_EN1: rd = ctc_enables;
      dcic_pkg::REG_EN2: rd = dcic_pkg::unpack6(uart_enables);
      dcic_pkg::REG_ST0:
        rd = hardware_mode ? {6'b0, in_service[0], in_service[11]} : {6'b0, line_ula_pending};
      dcic_pkg::REG_ST1: rd = hardware_mode ? in_service[10:3] : ctc_pending;
      dcic_pkg::REG_ST2:
        rd = hardware_mode ? {1'b0, in_service[13], in_service[2], in_service[2], 1'b0,
                              in_service[12], in_service[1], in_service[1]}
                           : dcic_pkg::unpack6(uart_pending);
      dcic_pkg::REG_DMA0: rd = {dma_enables[16], 5'b0, dma_enables[1:0]};
      dcic_pkg::REG_DMA1: rd = dma_enables[9:2];
      dcic_pkg::REG_DMA2: rd = dcic_pkg::unpack6(dma_enables[15:10]);
      default: hit = 1'b0;
    endcase
  end

  // next-state logic for one transaction
  logic taken, mf, dv, cs;
  always_comb begin
    line_enable_next = line_enable;
    ula_disable_next = ula_disable;
    expansion_bus_enable_next = expansion_bus_enable;
    int_signal_flag_next = int_signal_flag;
    line_target_next = line_target;
    vector_top_next = vector_top;
    stackless_nmi_next = stackless_nmi;
    hardware_mode_next = hardware_mode;
    nmi_return_next = nmi_return;
    uart_enables_next = uart_enables;
    uart_pending_next = uart_pending;
    ctc_enables_next = ctc_enables;
    ctc_pending_next = ctc_pending;
    line_ula_pending_next = line_ula_pending;
    dma_enables_next = dma_enables;
    in_service_next = in_service;
    reset_nmi_flags_next = reset_nmi_flags;
    taken = 1'b0;
    mf = 1'b0;
    dv = 1'b0;
    cs = 1'b0;
    case (opcode)
      dcic_pkg::OP_WRITE: begin
        taken = 1'b1;
        case (reg_number)
          dcic_pkg::REG_NMI: begin
            mf = wd[3];
            dv = wd[2];
            reset_nmi_flags_next = {wd[7], reset_nmi_flags[4] & wd[4], wd[3], wd[2],
                                    reset_nmi_flags[1:0]};
          end
          dcic_pkg::REG_LINEH: begin
            int_signal_flag_next = wd[7];
            ula_disable_next = wd[2];
            line_enable_next = wd[1];
            line_target_next[8] = wd[0];
          end
          dcic_pkg::REG_LINEL: line_target_next[7:0] = wd;
          dcic_pkg::REG_MODE: begin
            vector_top_next = wd[7:5];
            stackless_nmi_next = wd[3];
            hardware_mode_next = wd[0];
          end
          dcic_pkg::REG_NRL: nmi_return_next[7:0] = wd;
          dcic_pkg::REG_NRH: nmi_return_next[15:8] = wd;
          dcic_pkg::REG_EN0: begin
            expansion_bus_enable_next = wd[7];
            line_enable_next = wd[1];
            ula_disable_next = ~wd[0];
          end
          dcic_pkg::REG_EN1: begin
            ctc_enables_next = wd & CTC_MASK;
            cs = 1'b1;
          end
          dcic_pkg::REG_EN2: uart_enables_next = dcic_pkg::pack6(wd);
          dcic_pkg::REG_ST0:
            if (!hardware_mode) line_ula_pending_next = line_ula_pending & ~wd[1:0];
          dcic_pkg::REG_ST1:
            if (!hardware_mode) ctc_pending_next = ctc_pending & ~wd;
          dcic_pkg::REG_ST2:
            if (!hardware_mode) uart_pending_next = uart_pending & ~dcic_pkg::pack6(wd);
          dcic_pkg::REG_DMA0: begin
            dma_enables_next[16] = wd[7];
            dma_enables_next[1:0] = wd[1:0];
          end
          dcic_pkg::REG_DMA1: dma_enables_next[9:2] = wd & CTC_MASK;
          dcic_pkg::REG_DMA2: dma_enables_next[15:10] = dcic_pkg::pack6(wd);
          default: taken = 1'b0;
        endcase
      end
      dcic_pkg::OP_ULA: if (!ula_disable) line_ula_pending_next[0] = 1'b1;
      dcic_pkg::OP_LINE: if (line_enable) line_ula_pending_next[1] = 1'b1;
      dcic_pkg::OP_CTC:
        if (32'(idx) < CTC_CHANNELS) ctc_pending_next[idx[2:0]] = lvl;
      dcic_pkg::OP_UART: if (idx < 4'd6) uart_pending_next[idx[2:0]] = lvl;
      dcic_pkg::OP_ACK:
        if (pre.found) begin
          in_service_next[pre.slot] = 1'b1;
          case (pre.slot)
            4'd0: line_ula_pending_next[1] = 1'b0;
            4'd1: uart_pending_next[1:0] = 2'b00;
            4'd2: uart_pending_next[4:3] = 2'b00;
            4'd11: line_ula_pending_next[0] = 1'b0;
            4'd12: uart_pending_next[2] = 1'b0;
            4'd13: uart_pending_next[5] = 1'b0;
            default: ctc_pending_next[3'(pre.slot - 4'd3)] = 1'b0;
          endcase
        end
      dcic_pkg::OP_RETI:
        if (pre.first_is_found) in_service_next[pre.first_is] = 1'b0;
      dcic_pkg::OP_SETIS: if (idx < 4'd14) in_service_next[idx] = lvl;
      default: ;
    endcase
  end

  // result fields; vector is top bits over twice the slot number
  logic [7:0] vec;
  logic       dma;
  always_comb begin
    if (opcode == dcic_pkg::OP_ACK)
      vec = pre.found ? {vector_top, pre.slot, 1'b0} : 8'hFF;
    else
      vec = post.found ? {vector_top_next, post.slot, 1'b0} : 8'hFF;
    dma = |({uart_pending_next, ctc_pending_next, line_ula_pending_next}
            & dma_enables_next[15:0]);
  end

  // state and output registers
  assign out_load = accept;
  always_ff @(posedge clk) begin
    if (rst) begin
      line_enable <= 1'b0;
      ula_disable <= 1'b0;
      expansion_bus_enable <= 1'b0;
      int_signal_flag <= 1'b0;
      line_target <= '0;
      vector_top <= '0;
      stackless_nmi <= 1'b0;
      hardware_mode <= 1'b0;
      nmi_return <= '0;
      uart_enables <= '0;
      uart_pending <= '0;
      ctc_enables <= '0;
      ctc_pending <= '0;
      line_ula_pending <= '0;
      dma_enables <= '0;
      in_service <= '0;
      reset_nmi_flags <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        line_enable <= line_enable_next;
        ula_disable <= ula_disable_next;
        expansion_bus_enable <= expansion_bus_enable_next;
        int_signal_flag <= int_signal_flag_next;
        line_target <= line_target_next;
        vector_top <= vector_top_next;
        stackless_nmi <= stackless_nmi_next;
        hardware_mode <= hardware_mode_next;
        nmi_return <= nmi_return_next;
        uart_enables <= uart_enables_next;
        uart_pending <= uart_pending_next;
        ctc_enables <= ctc_enables_next;
        ctc_pending <= ctc_pending_next;
        line_ula_pending <= line_ula_pending_next;
        dma_enables <= dma_enables_next;
        in_service <= in_service_next;
        reset_nmi_flags <= reset_nmi_flags_next;
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, cs, dv, mf, dma, vec, post.found,
                       taken, (opcode == dcic_pkg::OP_READ) && hit,
                       (opcode == dcic_pkg::OP_READ) ? rd : 8'hFF};
    end
  end

  // assertions
  `DCIC_ASSERT_IMP(a_ctc_mask_en, clk, rst, 1'b1, (ctc_enables & ~CTC_MASK) == 8'h00,
                   "CTC enable beyond channel count")
  `DCIC_ASSERT_NEXT(a_ack_sets_is, clk, rst, accept && opcode == dcic_pkg::OP_ACK && pre.found,
                    in_service != 14'h0, "acknowledge did not mark in-service")
  `DCIC_ASSERT_IMP(a_hold_stall, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
                   "accepted while output stalled")
  `DCIC_ASSERT_NEXT(a_reset_flags, clk, rst, 1'b1,
                    reset_nmi_flags[1:0] == 2'b00, "hard or soft reset flag set")
endmodule

### test/tb_top.sv
// Testbench for the daisy-chain interrupt controller: directed and random event streams.
// Depends on dcic_pkg and daisy_chain_interrupt_controller_unit; self-checking predictor.
`timescale 1ns / 1ps
module tb_top;
  localparam int CTC_N = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  daisy_chain_interrupt_controller_unit #(.CTC_CHANNELS(CTC_N)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  // predicted controller state
  logic        p_line_en, p_ula_dis, p_exp_en, p_int_sig, p_stackless, p_hw_mode;
  logic [8:0]  p_line_target;
  logic [2:0]  p_vec_top;
  logic [15:0] p_nmi_ret;
  logic [5:0]  p_uart_en, p_uart_pend, p_flags;
  logic [7:0]  p_ctc_en, p_ctc_pend;
  logic [1:0]  p_lu_pend;
  logic [16:0] p_dma_en;
  logic [13:0] p_in_svc;

  logic [23:0] expected_results[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  function automatic logic slot_requesting(int s);
    logic [5:0] u;
    u = p_uart_pend & p_uart_en;
    case (s)
      0: return p_lu_pend[1] & p_line_en;
      1: return (|p_uart_pend[1:0]) && (|p_uart_en[1:0]);
      2: return (|p_uart_pend[4:3]) && (|p_uart_en[4:3]);
      11: return p_lu_pend[0] & ~p_ula_dis;
      12: return u[2];
      13: return u[5];
      default: return (s >= 3 && s <= 10) ? p_ctc_pend[s-3] & p_ctc_en[s-3] : 1'b0;
    endcase
  endfunction

  // winning slot, SLOTS when none
  function automatic int chain_winner();
    for (int i = 0; i < dcic_pkg::SLOTS; i++) begin
      if (p_in_svc[i]) return dcic_pkg::SLOTS;
      if (slot_requesting(i)) return i;
    end
    return dcic_pkg::SLOTS;
  endfunction

  function automatic void clear_slot(int s);
    case (s)
      0: p_lu_pend[1] = 1'b0;
      1: p_uart_pend[1:0] = 2'b00;
      2: p_uart_pend[4:3] = 2'b00;
      11: p_lu_pend[0] = 1'b0;
      12: p_uart_pend[2] = 1'b0;
      13: p_uart_pend[5] = 1'b0;
      default: if (s >= 3 && s <= 10) p_ctc_pend[s-3] = 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] bool8(logic c, logic [7:0] v);
    return c ? v : 8'h00;
  endfunction

  function automatic void reset_state();
    {p_line_en, p_ula_dis, p_exp_en, p_int_sig, p_stackless, p_hw_mode} = '0;
    p_line_target = '0; p_vec_top = '0; p_nmi_ret = '0;
    p_uart_en = '0; p_uart_pend = '0; p_flags = '0;
    p_ctc_en = '0; p_ctc_pend = '0; p_lu_pend = '0; p_dma_en = '0; p_in_svc = '0;
  endfunction

  // apply one event to the predicted state and return the packed result
  function automatic logic [23:0] controller_step(logic [31:0] d);
    logic [3:0] op;
    logic [7:0] r, b, rd, vec;
    logic [3:0] idx;
    logic lvl, hit, taken, mf, dv, cs, acked, dma;
    logic [1:0] im;
    logic [15:0] pend;
    int w;
    op = d[3:0]; r = d[11:4]; b = d[19:12]; idx = d[23:20]; lvl = d[24]; im = d[26:25];
    rd = 8'hFF; vec = 8'hFF; {hit, taken, mf, dv, cs, acked} = '0;
    case (op)
      dcic_pkg::OP_READ: begin
        hit = 1'b1;
        case (r)
          dcic_pkg::REG_NMI: rd = {p_flags[5], 2'b00, p_flags[4:0]};
          dcic_pkg::REG_PEND0: rd = {p_lu_pend, 2'b00, p_ctc_pend[3:0]};
          dcic_pkg::REG_LINEH:
            rd = {p_int_sig, 4'b0, p_ula_dis, p_line_en, p_line_target[8]};
          dcic_pkg::REG_LINEL: rd = p_line_target[7:0];
          dcic_pkg::REG_MODE: rd = {p_vec_top, 1'b0, p_stackless, im, p_hw_mode};
          dcic_pkg::REG_NRL: rd = p_nmi_ret[7:0];
          dcic_pkg::REG_NRH: rd = p_nmi_ret[15:8];
          dcic_pkg::REG_EN0: rd = {p_exp_en, 5'b0, p_line_en, ~p_ula_dis};
          dcic_pkg::REG_EN1: rd = p_ctc_en;
          dcic_pkg::REG_EN2: rd = {1'b0, p_uart_en[5:3], 1'b0, p_uart_en[2:0]};
          dcic_pkg::REG_ST0:
            rd = p_hw_mode ? {6'b0, p_in_svc[0], p_in_svc[11]} : {6'b0, p_lu_pend};
          dcic_pkg::REG_ST1: rd = p_hw_mode ? p_in_svc[10:3] : p_ctc_pend;
          dcic_pkg::REG_ST2:
            rd = p_hw_mode ? (bool8(p_in_svc[13], 8'h40) | bool8(p_in_svc[2], 8'h30) |
                              bool8(p_in_svc[12], 8'h04) | bool8(p_in_svc[1], 8'h03))
                           : {1'b0, p_uart_pend[5:3], 1'b0, p_uart_pend[2:0]};
          dcic_pkg::REG_DMA0: rd = {p_dma_en[16], 5'b0, p_dma_en[1:0]};
          dcic_pkg::REG_DMA1: rd = p_dma_en[9:2];
          dcic_pkg::REG_DMA2: rd = {1'b0, p_dma_en[15:13], 1'b0, p_dma_en[12:10]};
          default: hit = 1'b0;
        endcase
      end
      dcic_pkg::OP_WRITE: begin
        taken = 1'b1;
        case (r)
          dcic_pkg::REG_NMI: begin
            mf = b[3]; dv = b[2];
            p_flags = (p_flags & 6'h13) | {b[7], 1'b0, mf, dv, 2'b00};
            if (!b[4]) p_flags[4] = 1'b0;
          end
          dcic_pkg::REG_LINEH: begin
            p_int_sig = b[7]; p_ula_dis = b[2]; p_line_en = b[1]; p_line_target[8] = b[0];
          end
          dcic_pkg::REG_LINEL: p_line_target[7:0] = b;
          dcic_pkg::REG_MODE: begin
            p_vec_top = b[7:5]; p_stackless = b[3]; p_hw_mode = b[0];
          end
          dcic_pkg::REG_NRL: p_nmi_ret[7:0] = b;
          dcic_pkg::REG_NRH: p_nmi_ret[15:8] = b;
          dcic_pkg::REG_EN0: begin p_exp_en = b[7]; p_line_en = b[1]; p_ula_dis = ~b[0]; end
          dcic_pkg::REG_EN1: begin p_ctc_en = b; cs = 1'b1; end
          dcic_pkg::REG_EN2: p_uart_en = {b[6:4], b[2:0]};
          dcic_pkg::REG_ST0: if (!p_hw_mode) p_lu_pend &= ~b[1:0];
          dcic_pkg::REG_ST1: if (!p_hw_mode) p_ctc_pend &= ~b;
          dcic_pkg::REG_ST2: if (!p_hw_mode) p_uart_pend &= ~{b[6:4], b[2:0]};
          dcic_pkg::REG_DMA0: begin p_dma_en[16] = b[7]; p_dma_en[1:0] = b[1:0]; end
          dcic_pkg::REG_DMA1: p_dma_en[9:2] = b;
          dcic_pkg::REG_DMA2: p_dma_en[15:10] = {b[6:4], b[2:0]};
          default: taken = 1'b0;
        endcase
      end
      dcic_pkg::OP_ULA: if (!p_ula_dis) p_lu_pend[0] = 1'b1;
      dcic_pkg::OP_LINE: if (p_line_en) p_lu_pend[1] = 1'b1;
      dcic_pkg::OP_CTC: if (idx < CTC_N) p_ctc_pend[idx[2:0]] = lvl;
      dcic_pkg::OP_UART: if (idx < 6) p_uart_pend[idx[2:0]] = lvl;
      dcic_pkg::OP_ACK: begin
        acked = 1'b1;
        w = chain_winner();
        if (w < dcic_pkg::SLOTS) begin
          p_in_svc[w] = 1'b1;
          clear_slot(w);
          vec = {p_vec_top, 5'(w << 1)};
        end
      end
      dcic_pkg::OP_RETI: begin
        for (int i = 0; i < dcic_pkg::SLOTS; i++)
          if (p_in_svc[i]) begin p_in_svc[i] = 1'b0; break; end
      end
      dcic_pkg::OP_SETIS: if (idx < dcic_pkg::SLOTS) p_in_svc[idx] = lvl;
      default: ;
    endcase
    w = chain_winner();
    if (!acked && w < dcic_pkg::SLOTS) vec = {p_vec_top, 5'(w << 1)};
    pend = {p_uart_pend, p_ctc_pend, p_lu_pend};
    dma = |(pend & p_dma_en[15:0]);
    return {1'b0, cs, dv, mf, dma, vec, logic'(w < dcic_pkg::SLOTS), taken, hit, rd};
  endfunction

  // send one event, predicting its result on acceptance; valid stays up afterwards
  task automatic send_event(logic [3:0] op, logic [7:0] r = 8'h00, logic [7:0] b = 8'h00,
                            logic [3:0] idx = 4'd0, logic lvl = 1'b0,
                            logic [1:0] im = 2'd0);
    logic [31:0] d;
    d = {5'b0, im, lvl, idx, b, r, op};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(controller_step(d));
  endtask

  task automatic send_random_field(logic [3:0] op);
    send_event(op, 8'($urandom), 8'($urandom), 4'($urandom), 1'($urandom), 2'($urandom));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    logic [23:0] e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_axis_tdata[7:0] !== e[7:0]) begin
          $error("read_data exp %h got %h", e[7:0], m_axis_tdata[7:0]); errors++;
        end
        if (m_axis_tdata[8] !== e[8]) begin
          $error("read_hit exp %b got %b", e[8], m_axis_tdata[8]); errors++;
        end
        if (m_axis_tdata[9] !== e[9]) begin
          $error("write_taken exp %b got %b", e[9], m_axis_tdata[9]); errors++;
        end
        if (m_axis_tdata[10] !== e[10]) begin
          $error("irq_request exp %b got %b", e[10], m_axis_tdata[10]); errors++;
        end
        if (m_axis_tdata[18:11] !== e[18:11]) begin
          $error("vector_out exp %h got %h", e[18:11], m_axis_tdata[18:11]); errors++;
        end
        if (m_axis_tdata[19] !== e[19]) begin
          $error("dma_request exp %b got %b", e[19], m_axis_tdata[19]); errors++;
        end
        if (m_axis_tdata[20] !== e[20]) begin
          $error("mf_nmi_strobe exp %b got %b", e[20], m_axis_tdata[20]); errors++;
        end
        if (m_axis_tdata[21] !== e[21]) begin
          $error("divmmc_nmi_strobe exp %b got %b", e[21], m_axis_tdata[21]); errors++;
        end
        if (m_axis_tdata[22] !== e[22]) begin
          $error("ctc_enable_strobe exp %b got %b", e[22], m_axis_tdata[22]); errors++;
        end
      end
    end
  end

  // directed: every opcode, selected registers, edge cases
  task automatic test_directed();
    send_event(dcic_pkg::OP_READ, dcic_pkg::REG_MODE, 8'h00, 4'd0, 1'b0, 2'd3);
    send_event(dcic_pkg::OP_READ, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, 8'h55, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_MODE, 8'hE1);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_EN0, 8'h82);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_EN1, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_EN2, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_DMA0, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_DMA1, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_DMA2, 8'hFF);
    send_event(dcic_pkg::OP_LINE);
    send_event(dcic_pkg::OP_ULA);
    send_event(dcic_pkg::OP_CTC, 8'h00, 8'h00, 4'd7, 1'b1);
    send_event(dcic_pkg::OP_UART, 8'h00, 8'h00, 4'd5, 1'b1);
    send_event(dcic_pkg::OP_UART, 8'h00, 8'h00, 4'd15, 1'b1);
    send_event(dcic_pkg::OP_ACK);
    send_event(dcic_pkg::OP_READ, dcic_pkg::REG_ST0);
    send_event(dcic_pkg::OP_RETI);
    send_event(dcic_pkg::OP_SETIS, 8'h00, 8'h00, 4'd13, 1'b1);
    send_event(dcic_pkg::OP_SETIS, 8'h00, 8'h00, 4'd14, 1'b1);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_ST2, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_NMI, 8'hFF);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_LINEH, 8'hFF);
    send_event(4'd15, 8'hFF, 8'hFF, 4'd15, 1'b1, 2'd3);
    send_event(dcic_pkg::OP_WRITE, dcic_pkg::REG_MODE, 8'h00);
  endtask

  // random: interrupt-flow weighted sequences plus noise
  task automatic test_random(int count);
    logic [7:0] regs[16];
    int k;
    regs = '{dcic_pkg::REG_NMI, dcic_pkg::REG_PEND0, dcic_pkg::REG_LINEH,
             dcic_pkg::REG_LINEL, dcic_pkg::REG_MODE, dcic_pkg::REG_NRL, dcic_pkg::REG_NRH,
             dcic_pkg::REG_EN0, dcic_pkg::REG_EN1, dcic_pkg::REG_EN2, dcic_pkg::REG_ST0,
             dcic_pkg::REG_ST1, dcic_pkg::REG_ST2, dcic_pkg::REG_DMA0,
             dcic_pkg::REG_DMA1, dcic_pkg::REG_DMA2};
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 15) send_event(dcic_pkg::OP_READ, regs[$urandom_range(15)], 8'h00, 4'd0,
                             1'b0, 2'($urandom));
      else if (k < 30) send_event(dcic_pkg::OP_WRITE, regs[$urandom_range(15)],
                                  8'($urandom));
      else if (k < 35) send_random_field(dcic_pkg::OP_READ);
      else if (k < 38) send_random_field(dcic_pkg::OP_WRITE);
      else if (k < 45) send_random_field(dcic_pkg::OP_ULA);
      else if (k < 52) send_random_field(dcic_pkg::OP_LINE);
      else if (k < 62) send_event(dcic_pkg::OP_CTC, 8'($urandom), 8'($urandom),
                                  4'($urandom_range(8)), 1'($urandom_range(3) != 0));
      else if (k < 70) send_event(dcic_pkg::OP_UART, 8'($urandom), 8'($urandom),
                                  4'($urandom_range(6)), 1'($urandom_range(3) != 0));
      else if (k < 82) send_random_field(dcic_pkg::OP_ACK);
      else if (k < 92) send_random_field(dcic_pkg::OP_RETI);
      else if (k < 97) send_random_field(dcic_pkg::OP_SETIS);
      else send_random_field(4'($urandom_range(9, 15)));
    end
  endtask

  initial begin
    reset_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 25; recv_idle_pct = 87;
    test_random(600);
    // hold off the sender until everything is back
    drain_results();
    send_idle_pct = 87; recv_idle_pct = 25;
    test_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(700);
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
